// ===== rtl/bps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pkg: shared definitions for the beep pattern sequencer
// Register indexes, reset values, field widths, operation codes and the queue control bundle.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int DURATION_BITS_DEF = 24;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int STEP_W     = 10;
  localparam int BEEP_CNT_W = 8;
  localparam int REPORT_W   = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_QUIET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEEP       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP  = 2'd3;

  localparam logic [CFG_DATA_W-1:0] LEAD_QUIET_RST = 24'd100;
  localparam logic [CFG_DATA_W-1:0] BEEP_RST       = 24'd1250;
  localparam logic [CFG_DATA_W-1:0] GAP_RST        = 24'd500;
  localparam logic [STEP_W-1:0]     TICK_STEP_RST  = 10'd100;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

endpackage

// ===== rtl/beep_pattern_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beep_pattern_sequencer: timed buzzer pattern sequencer
// Queues quiet and sounding segments and plays them out on an active-low pin.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result has been shown. operation_i selects a timer tick or a beep
// request, and beep_count_i gives the number of beeps of a request.
// Each item gives one result, shown for one cycle with done_o high: the pin
// level, the queue fill after the item and the segments added by a request.
// The receiver cannot stall; it must take the result in that cycle.
// A tick passes S_TICK and S_DONE, with S_LOAD between them when a segment is
// loaded from the queue, since the queue memory read is registered. A request
// writes one segment per cycle in S_PUSH until its segments are all queued or
// the queue is full, then passes S_DONE. One saturating subtractor serves both
// countdowns. The four registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i, by the user only while the block is idle; the block does not
// enforce it. Reset restores the register defaults, empties the queue, clears
// both countdowns and silences the buzzer.
// ----------------------------------------------------------------------------
module beep_pattern_sequencer #(
  parameter int QUEUE_DEPTH   = bps_pkg::QUEUE_DEPTH_DEF,
  parameter int DURATION_BITS = bps_pkg::DURATION_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               operation_i,
  input  logic [bps_pkg::BEEP_CNT_W-1:0]     beep_count_i,
  input  logic                               cfg_we_i,
  input  logic [bps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bps_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output logic                               done_o,
  output logic                               buzzer_off_o,
  output logic [bps_pkg::REPORT_W-1:0]       queue_fill_o,
  output logic [bps_pkg::REPORT_W-1:0]       segments_added_o
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SEG_W = DURATION_BITS + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PUSH = 3'd1;
  localparam logic [2:0] S_TICK = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_BEEP = 2'd1;
  localparam logic [1:0] PH_GAP  = 2'd2;

  logic [bps_pkg::CFG_DATA_W-1:0] lead_q, beep_q, gap_q;
  logic [bps_pkg::STEP_W-1:0]     step_q;

  logic [2:0]                     state_q, state_d;
  logic [1:0]                     phase_q, phase_d;
  logic [bps_pkg::BEEP_CNT_W-1:0] pairs_q, pairs_d;
  logic [CNT_W-1:0]               added_q, added_d;
  logic [DURATION_BITS-1:0]       sound_q, sound_d;
  logic [DURATION_BITS-1:0]       quiet_q, quiet_d;
  logic                           pin_q, pin_d;

  logic [31:0]                    lead_ext, beep_ext, gap_ext;
  logic [DURATION_BITS-1:0]       lead_dur, beep_dur, gap_dur;
  logic [SEG_W-1:0]               push_seg;
  logic [SEG_W-1:0]               head_seg;
  logic [CNT_W-1:0]               q_count;
  logic                           q_full;
  bps_pkg::q_ctrl_t               q_ctrl;
  logic [DURATION_BITS-1:0]       sub_in, sub_out;
  logic [31:0]                    fill_ext, added_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= bps_pkg::LEAD_QUIET_RST;
      beep_q <= bps_pkg::BEEP_RST;
      gap_q  <= bps_pkg::GAP_RST;
      step_q <= bps_pkg::TICK_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bps_pkg::CFG_LEAD_QUIET: lead_q <= cfg_wdata_i;
        bps_pkg::CFG_BEEP:       beep_q <= cfg_wdata_i;
        bps_pkg::CFG_GAP:        gap_q  <= cfg_wdata_i;
        bps_pkg::CFG_TICK_STEP:  step_q <= cfg_wdata_i[bps_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign lead_ext = 32'(lead_q);
  assign beep_ext = 32'(beep_q);
  assign gap_ext  = 32'(gap_q);
  assign lead_dur = lead_ext[DURATION_BITS-1:0];
  assign beep_dur = beep_ext[DURATION_BITS-1:0];
  assign gap_dur  = gap_ext[DURATION_BITS-1:0];

  always_comb begin
    case (phase_q)
      PH_LEAD: push_seg = {1'b1, lead_dur};
      PH_BEEP: push_seg = {1'b0, beep_dur};
      PH_GAP:  push_seg = {1'b1, gap_dur};
      default: push_seg = {1'b1, lead_dur};
    endcase
  end

  bps_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (SEG_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (q_ctrl),
    .wdata_i (push_seg),
    .rdata_o (head_seg),
    .count_o (q_count),
    .full_o  (q_full)
  );

  assign sub_in = (sound_q != '0) ? sound_q : quiet_q;

  bps_satsub #(
    .DURATION_BITS (DURATION_BITS)
  ) u_satsub (
    .minuend_i (sub_in),
    .step_i    (step_q),
    .result_o  (sub_out)
  );

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    pairs_d = pairs_q;
    added_d = added_q;
    sound_d = sound_q;
    quiet_d = quiet_q;
    pin_d   = pin_q;
    q_ctrl  = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          phase_d = PH_LEAD;
          pairs_d = beep_count_i;
          added_d = '0;
          state_d = (operation_i == bps_pkg::OP_REQUEST) ? S_PUSH : S_TICK;
        end
      end
      S_PUSH: begin
        if (q_full) begin
          state_d = S_DONE;
        end else begin
          q_ctrl.push = 1'b1;
          added_d     = added_q + CNT_W'(1);
          case (phase_q)
            PH_LEAD: begin
              if (pairs_q == '0) begin
                state_d = S_DONE;
              end else begin
                phase_d = PH_BEEP;
              end
            end
            PH_BEEP: phase_d = PH_GAP;
            default: begin
              pairs_d = pairs_q - bps_pkg::BEEP_CNT_W'(1);
              phase_d = PH_BEEP;
              if (pairs_q == bps_pkg::BEEP_CNT_W'(1)) begin
                state_d = S_DONE;
              end
            end
          endcase
        end
      end
      S_TICK: begin
        state_d = S_DONE;
        if (sound_q != '0) begin
          pin_d   = 1'b0;
          sound_d = sub_out;
        end else if (quiet_q != '0) begin
          pin_d   = 1'b1;
          quiet_d = sub_out;
        end else if (q_count != '0) begin
          state_d = S_LOAD;
        end else begin
          pin_d = 1'b1;
        end
      end
      S_LOAD: begin
        q_ctrl.pop = 1'b1;
        state_d    = S_DONE;
        if (head_seg[DURATION_BITS]) begin
          quiet_d = head_seg[DURATION_BITS-1:0];
          pin_d   = 1'b1;
        end else begin
          sound_d = head_seg[DURATION_BITS-1:0];
          pin_d   = 1'b0;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_LEAD;
      pairs_q <= '0;
      added_q <= '0;
      sound_q <= '0;
      quiet_q <= '0;
      pin_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      pairs_q <= pairs_d;
      added_q <= added_d;
      sound_q <= sound_d;
      quiet_q <= quiet_d;
      pin_q   <= pin_d;
    end
  end

  assign fill_ext         = 32'(q_count);
  assign added_ext        = 32'(added_q);
  assign busy             = (state_q != S_IDLE);
  assign done_o           = (state_q == S_DONE);
  assign buzzer_off_o     = pin_q;
  assign queue_fill_o     = fill_ext[bps_pkg::REPORT_W-1:0];
  assign segments_added_o = added_ext[bps_pkg::REPORT_W-1:0];

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for more than one cycle");

  a_pin_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == S_TICK || state_q == S_LOAD) |=> $stable(pin_q))
    else $error("buzzer pin changed outside a tick");

  a_no_load_when_counting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (sound_q == '0 && quiet_q == '0))
    else $error("segment loaded while a countdown is still running");

endmodule

// ===== rtl/bps_satsub.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_satsub: saturating subtractor
// Subtracts the tick step from a remaining time, stopping at zero.
// ----------------------------------------------------------------------------
module bps_satsub #(
  parameter int DURATION_BITS = bps_pkg::DURATION_BITS_DEF
) (
  input  logic [DURATION_BITS-1:0]       minuend_i,
  input  logic [bps_pkg::STEP_W-1:0]     step_i,
  output logic [DURATION_BITS-1:0]       result_o
);

  logic [31:0] a_ext;
  logic [31:0] b_ext;
  logic [31:0] diff;

  assign a_ext    = 32'(minuend_i);
  assign b_ext    = 32'(step_i);
  assign diff     = (a_ext > b_ext) ? (a_ext - b_ext) : 32'd0;
  assign result_o = diff[DURATION_BITS-1:0];

endmodule

// ===== rtl/bps_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_queue: segment queue
// Circular buffer in a memory with head and tail pointers and a fill count.
// The entry at the head is read into a register every cycle.
// ----------------------------------------------------------------------------
module bps_queue #(
  parameter int DEPTH = bps_pkg::QUEUE_DEPTH_DEF,
  parameter int WIDTH = bps_pkg::DURATION_BITS_DEF + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bps_pkg::q_ctrl_t             ctrl_i,
  input  logic [WIDTH-1:0]             wdata_i,
  output logic [WIDTH-1:0]             rdata_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o,
  output logic                         full_o
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic [AW-1:0]    head_q, head_d;
  logic [AW-1:0]    tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign count_o = count_q;
  assign rdata_o = rdata_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.push) begin
      tail_d  = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
      count_d = count_d + CNT_W'(1);
    end
    if (ctrl_i.pop) begin
      head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
      count_d = count_d - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= wdata_i;
    end
    rdata_q <= mem[head_q];
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> !full_o) else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> (count_q != '0)) else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH)) else $error("fill count beyond queue depth");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the beep pattern sequencer
// Sends timer ticks and beep requests through the start/busy handshake and
// checks every result against a cycle-free model of the segment queue, the
// two countdowns and the pin level. Register settings are changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_WAIT       = 40;

  typedef struct packed {
    logic                         buzzer_off;
    logic [bps_pkg::REPORT_W-1:0] queue_fill;
    logic [bps_pkg::REPORT_W-1:0] segments_added;
  } report_t;

  logic                           clk_i        = 1'b0;
  logic                           rst_ni       = 1'b0;
  logic                           start        = 1'b0;
  logic                           busy;
  logic                           operation_i  = bps_pkg::OP_TICK;
  logic [bps_pkg::BEEP_CNT_W-1:0] beep_count_i = '0;
  logic                           cfg_we_i     = 1'b0;
  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_idx_i    = bps_pkg::CFG_LEAD_QUIET;
  logic [bps_pkg::CFG_DATA_W-1:0] cfg_wdata_i  = '0;
  logic                           done_o;
  logic                           buzzer_off_o;
  logic [bps_pkg::REPORT_W-1:0]   queue_fill_o;
  logic [bps_pkg::REPORT_W-1:0]   segments_added_o;

  // Model of the block.
  logic [bps_pkg::DURATION_BITS_DEF:0]   seg_store [bps_pkg::QUEUE_DEPTH_DEF];
  logic [3:0]                            rd_ptr      = '0;
  logic [bps_pkg::REPORT_W-1:0]          fill        = '0;
  logic [bps_pkg::DURATION_BITS_DEF-1:0] sound_left  = '0;
  logic [bps_pkg::DURATION_BITS_DEF-1:0] quiet_left  = '0;
  logic                                  pin         = 1'b1;
  logic [bps_pkg::CFG_DATA_W-1:0]        lead_ms     = bps_pkg::LEAD_QUIET_RST;
  logic [bps_pkg::CFG_DATA_W-1:0]        beep_len_ms = bps_pkg::BEEP_RST;
  logic [bps_pkg::CFG_DATA_W-1:0]        gap_len_ms  = bps_pkg::GAP_RST;
  logic [bps_pkg::STEP_W-1:0]            step_ms     = bps_pkg::TICK_STEP_RST;

  report_t pending_reports[$];

  int  mismatches    = 0;
  int  results_seen  = 0;
  int  ticks_sent    = 0;
  int  requests_sent = 0;
  int  full_requests = 0;
  int  settings_used = 1;
  int  idle_count    = 0;
  bit  no_idle       = 1'b0;

  beep_pattern_sequencer DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .beep_count_i     (beep_count_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .buzzer_off_o     (buzzer_off_o),
    .queue_fill_o     (queue_fill_o),
    .segments_added_o (segments_added_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit enqueue_segment(input logic [bps_pkg::DURATION_BITS_DEF:0] seg);
    logic [3:0] wr_ptr;
    if (fill >= bps_pkg::QUEUE_DEPTH_DEF) begin
      return 1'b0;
    end
    wr_ptr = rd_ptr + fill[3:0];
    seg_store[wr_ptr] = seg;
    fill = fill + 1'b1;
    return 1'b1;
  endfunction

  function automatic report_t play_item(input logic op,
                                        input logic [bps_pkg::BEEP_CNT_W-1:0] cnt);
    logic [bps_pkg::REPORT_W-1:0]        added;
    logic [bps_pkg::DURATION_BITS_DEF:0] seg;
    report_t                             rep;
    added = '0;
    if (op == bps_pkg::OP_REQUEST) begin
      if (enqueue_segment({1'b1, lead_ms})) begin
        added = bps_pkg::REPORT_W'(1);
        for (int i = 0; i < cnt; i++) begin
          if (!enqueue_segment({1'b0, beep_len_ms})) break;
          added = added + 1'b1;
          if (!enqueue_segment({1'b1, gap_len_ms})) break;
          added = added + 1'b1;
        end
      end
    end else if (sound_left != 0) begin
      pin = 1'b0;
      sound_left = (sound_left > step_ms) ? sound_left - step_ms : '0;
    end else if (quiet_left != 0) begin
      pin = 1'b1;
      quiet_left = (quiet_left > step_ms) ? quiet_left - step_ms : '0;
    end else if (fill != 0) begin
      seg = seg_store[rd_ptr];
      rd_ptr = rd_ptr + 1'b1;
      fill = fill - 1'b1;
      if (seg[bps_pkg::DURATION_BITS_DEF]) begin
        quiet_left = seg[bps_pkg::DURATION_BITS_DEF-1:0];
        pin = 1'b1;
      end else begin
        sound_left = seg[bps_pkg::DURATION_BITS_DEF-1:0];
        pin = 1'b0;
      end
    end else begin
      pin = 1'b1;
    end
    rep.buzzer_off     = pin;
    rep.queue_fill     = fill;
    rep.segments_added = added;
    return rep;
  endfunction

  always @(negedge clk_i) begin
    report_t want;
    if (!rst_ni) begin
      idle_count <= 0;
    end else begin
      if ((start && !busy) || done_o) begin
        idle_count <= 0;
      end else if (idle_count + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", pending_reports.size());
        $display("Mismatches found");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
      if (done_o) begin
        results_seen++;
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with no item outstanding", $realtime);
          end
        end else begin
          want = pending_reports.pop_front();
          if (want != {buzzer_off_o, queue_fill_o, segments_added_o}) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: expected off=%0b fill=%0d added=%0d, got off=%0b fill=%0d added=%0d",
                       $realtime, want.buzzer_off, want.queue_fill, want.segments_added,
                       buzzer_off_o, queue_fill_o, segments_added_o);
            end
          end
        end
      end
    end
  end

  task automatic send_item(input logic op, input logic [bps_pkg::BEEP_CNT_W-1:0] cnt);
    int r;
    int gap_len;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) begin
      gap_len = 0;
    end else if (r < 90) begin
      gap_len = $urandom_range(1, 20);
    end else begin
      gap_len = $urandom_range(30, 80);
    end
    if (gap_len > 0) begin
      start <= 1'b0;
      repeat (gap_len) @(posedge clk_i);
    end
    start        <= 1'b1;
    operation_i  <= op;
    beep_count_i <= cnt;
    do @(negedge clk_i); while (busy);
    pending_reports.push_back(play_item(op, cnt));
    if (op == bps_pkg::OP_REQUEST) begin
      requests_sent++;
      if (fill == bps_pkg::QUEUE_DEPTH_DEF) full_requests++;
    end else begin
      ticks_sent++;
    end
    @(posedge clk_i);
  endtask

  task automatic settle_block();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_reports.size() != 0 || busy);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic configure(input logic [bps_pkg::CFG_DATA_W-1:0] lead, beep, gap, step_word);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= bps_pkg::CFG_LEAD_QUIET;
    cfg_wdata_i <= lead;
    @(posedge clk_i);
    cfg_idx_i   <= bps_pkg::CFG_BEEP;
    cfg_wdata_i <= beep;
    @(posedge clk_i);
    cfg_idx_i   <= bps_pkg::CFG_GAP;
    cfg_wdata_i <= gap;
    @(posedge clk_i);
    cfg_idx_i   <= bps_pkg::CFG_TICK_STEP;
    cfg_wdata_i <= step_word;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lead_ms     = lead;
    beep_len_ms = beep;
    gap_len_ms  = gap;
    step_ms     = step_word[bps_pkg::STEP_W-1:0];
    settings_used++;
  endtask

  task automatic run_random(input int n_items, input int req_pct);
    int r;
    logic [bps_pkg::BEEP_CNT_W-1:0] cnt;
    for (int n = 0; n < n_items; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 2) settle_block();
      if ($urandom_range(0, 99) < req_pct) begin
        r = $urandom_range(0, 99);
        if (r < 70) cnt = bps_pkg::BEEP_CNT_W'($urandom_range(0, 4));
        else if (r < 90) cnt = bps_pkg::BEEP_CNT_W'($urandom_range(5, 15));
        else cnt = bps_pkg::BEEP_CNT_W'($urandom_range(0, 255));
        send_item(bps_pkg::OP_REQUEST, cnt);
      end else begin
        send_item(bps_pkg::OP_TICK, bps_pkg::BEEP_CNT_W'($urandom_range(0, 255)));
      end
    end
    no_idle = 1'b0;
  endtask

  function automatic logic [bps_pkg::CFG_DATA_W-1:0] spread_ms(input int low_shift);
    return bps_pkg::CFG_DATA_W'($urandom >> $urandom_range(low_shift, 31));
  endfunction

  function automatic logic [bps_pkg::CFG_DATA_W-1:0] pick_ms(input int lo, input int hi);
    return bps_pkg::CFG_DATA_W'($urandom_range(lo, hi));
  endfunction

  task automatic test_directed();
    send_item(bps_pkg::OP_TICK, 8'hFF);
    send_item(bps_pkg::OP_REQUEST, 8'd0);
    send_item(bps_pkg::OP_TICK, 8'd0);
    send_item(bps_pkg::OP_TICK, 8'd0);
    // Zero-length segments and a countdown that saturates at zero.
    configure(24'd0, 24'd0, 24'd1500, 24'd1000);
    send_item(bps_pkg::OP_REQUEST, 8'd1);
    repeat (6) send_item(bps_pkg::OP_TICK, 8'd0);
    // Filling the queue: a request on a full queue, a pair cut after its beep.
    configure(24'd0, 24'd0, 24'd0, 24'hFFFC00 | 24'd100);
    send_item(bps_pkg::OP_REQUEST, 8'hFF);
    send_item(bps_pkg::OP_REQUEST, 8'd7);
    repeat (2) send_item(bps_pkg::OP_TICK, 8'd0);
    send_item(bps_pkg::OP_REQUEST, 8'hFF);
    repeat (3) send_item(bps_pkg::OP_TICK, 8'd0);
    send_item(bps_pkg::OP_REQUEST, 8'hFF);
  endtask

  task automatic test_short_segments();
    configure(pick_ms(0, 300), pick_ms(0, 300), pick_ms(0, 300), 24'd100);
    run_random(200, 20);
  endtask

  task automatic test_single_ms_step();
    configure(pick_ms(0, 5), pick_ms(0, 5), pick_ms(0, 5), 24'd1);
    run_random(150, 20);
  endtask

  task automatic test_saturating_step();
    configure(24'd999, 24'd1023, 24'd2047, 24'd1023);
    run_random(75, 25);
    configure(pick_ms(0, 2000), pick_ms(0, 2000), pick_ms(0, 2000), 24'd1000);
    run_random(75, 25);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      configure(spread_ms(16), spread_ms(16), spread_ms(16),
                {14'($urandom_range(0, 16383)), 10'($urandom_range(1, 1023))});
      run_random(50, 20);
    end
  endtask

  task automatic test_zero_step();
    configure(pick_ms(1, 200), pick_ms(1, 200), pick_ms(1, 200), 24'd0);
    run_random(60, 30);
  endtask

  task automatic test_extreme_durations();
    configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h0003FF);
    run_random(60, 60);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_short_segments();
    test_single_ms_step();
    test_saturating_step();
    test_random_settings();
    test_zero_step();
    test_extreme_durations();
    settle_block();
    repeat (END_WAIT) @(posedge clk_i);
    mismatches += pending_reports.size();
    $display("Covered %0d ticks and %0d beep requests under %0d register settings.",
             ticks_sent, requests_sent, settings_used);
    $display("%0d results checked; %0d requests left the queue full.",
             results_seen, full_requests);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
